// ===== rtl/core/trc_pkg.sv =====
// Package for the triggered capture ring: sizes, codes and state type.
// Used by trc_ring and triggered_capture_ring_top; depends on nothing.
package trc_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int HALF_RING  = RING_DEPTH / 2;
    localparam int MAX_WINDOW = 64;
    localparam int CNT_W      = 7;
    localparam int SAMP_W     = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_DISPLAY = 1'b1;

    localparam logic [1:0] TRIG_FREE = 2'd0;
    localparam logic [1:0] TRIG_RISE = 2'd1;
    localparam logic [1:0] TRIG_FALL = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_LEVEL = 1'b1;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic signed [SAMP_W-1:0] t_samp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH,
        ST_RD,
        ST_LD
    } t_state;

endpackage

// ===== rtl/core/trc_ring.sv =====
// Stereo sample ring: two synchronous memories, one write and one read port.
// Read data is registered. Depends on trc_pkg.
module trc_ring (
    input  logic          i_clk,
    input  logic          i_we,
    input  trc_pkg::t_ptr  i_waddr,
    input  trc_pkg::t_samp i_wleft,
    input  trc_pkg::t_samp i_wright,
    input  trc_pkg::t_ptr  i_raddr,
    output trc_pkg::t_samp o_rleft,
    output trc_pkg::t_samp o_rright
);
    import trc_pkg::*;

    t_samp r_left_mem  [RING_DEPTH];
    t_samp r_right_mem [RING_DEPTH];
    t_samp r_rleft;
    t_samp r_rright;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_left_mem[i_waddr]  <= i_wleft;
            r_right_mem[i_waddr] <= i_wright;
        end
        r_rleft  <= r_left_mem[i_raddr];
        r_rright <= r_right_mem[i_raddr];
    end

    assign o_rleft  = r_rleft;
    assign o_rright = r_rright;

endmodule

// ===== rtl/core/triggered_capture_ring_top.sv =====
// Triggered capture ring top level: request decode, trigger search and readout.
// Depends on trc_pkg and trc_ring.
//
// After reset the ring is cleared by a pass over all RING_DEPTH (4096) entries,
// during which no request is taken; configuration writes are taken at any time.
// A display request with a nonzero count in free run starts readout at once;
// with an edge trigger it first walks the left channel backwards through the
// single ring read port, one candidate a cycle, over up to RING_DEPTH/2
// candidates, and stops early at the first crossing. Readout reads each pair
// in ST_RD and loads it into the output register in ST_LD; ST_RD waits while
// the output register holds a pair not yet taken. Each request is finished
// before the next is taken; the last pair may still wait in the output
// register while new requests are accepted.
module triggered_capture_ring_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [trc_pkg::SAMP_W-1:0]          i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] sample_left, [31:16] sample_right, [38:32] display_count, [39] zero
    input  logic [trc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] kind
    input  logic                                s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] out_left, [31:16] out_right
    output logic [trc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast
);
    import trc_pkg::*;

    t_state          r_state, n_state;
    t_ptr            r_wp, n_wp;
    t_ptr            r_addr, n_addr;
    t_ptr            r_start, n_start;
    logic [PTR_W-1:0] r_scnt, n_scnt;
    logic [CNT_W-1:0] r_rem, n_rem;
    t_samp           r_cur, n_cur;
    logic [1:0]      r_mode;
    t_samp           r_level;
    logic            r_out_valid, n_out_valid;
    t_samp           r_out_left, n_out_left;
    t_samp           r_out_right, n_out_right;
    logic            r_out_last, n_out_last;

    logic            mem_we;
    t_ptr            mem_waddr;
    t_samp           mem_wleft, mem_wright;
    t_ptr            mem_raddr;
    t_samp           mem_rleft, mem_rright;

    logic            in_fire, out_fire;
    logic [CNT_W-1:0] req_cnt_raw, req_cnt;
    t_ptr            req_start;
    logic            crossing;

    trc_ring u_ring (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wleft  (mem_wleft),
        .i_wright (mem_wright),
        .i_raddr  (mem_raddr),
        .o_rleft  (mem_rleft),
        .o_rright (mem_rright)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = r_out_valid & m_axis_tready;

    assign req_cnt_raw = s_axis_tdata[2*SAMP_W +: CNT_W];
    assign req_cnt     = (req_cnt_raw > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : req_cnt_raw;
    assign req_start   = r_wp - PTR_W'(req_cnt);

    // r_cur is the candidate, memory data the sample one step older
    always_comb begin
        crossing = 1'b0;
        if (r_mode == TRIG_RISE) begin
            crossing = (mem_rleft < r_level) && (r_cur >= r_level);
        end else if (r_mode == TRIG_FALL) begin
            crossing = (mem_rleft > r_level) && (r_cur <= r_level);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_addr      = r_addr;
        n_start     = r_start;
        n_scnt      = r_scnt;
        n_rem       = r_rem;
        n_cur       = r_cur;
        n_out_valid = r_out_valid & ~out_fire;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wleft   = t_samp'(s_axis_tdata[0 +: SAMP_W]);
        mem_wright  = t_samp'(s_axis_tdata[SAMP_W +: SAMP_W]);
        mem_raddr   = r_addr;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_addr;
                mem_wleft  = '0;
                mem_wright = '0;
                n_addr     = r_addr + PTR_W'(1);
                if (r_addr == PTR_W'(RING_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == KIND_WRITE) begin
                        mem_we = 1'b1;
                        n_wp   = r_wp + PTR_W'(1);
                    end else if (req_cnt != '0) begin
                        n_rem   = req_cnt;
                        n_start = req_start;
                        n_addr  = req_start;
                        n_scnt  = '0;
                        if (r_mode == TRIG_RISE || r_mode == TRIG_FALL) begin
                            n_state = ST_SRCH;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                end
            end
            ST_SRCH: begin
                mem_raddr = r_addr;
                n_addr    = r_addr - PTR_W'(1);
                n_cur     = mem_rleft;
                n_scnt    = r_scnt + PTR_W'(1);
                if (r_scnt >= PTR_W'(2) && crossing) begin
                    n_start = r_addr + PTR_W'(2);
                    n_addr  = r_addr + PTR_W'(2);
                    n_state = ST_RD;
                end else if (r_scnt == PTR_W'(HALF_RING + 1)) begin
                    n_addr  = r_start;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                mem_raddr = r_addr;
                if (!r_out_valid || m_axis_tready) begin
                    n_addr  = r_addr + PTR_W'(1);
                    n_state = ST_LD;
                end
            end
            ST_LD: begin
                n_out_valid = 1'b1;
                n_out_left  = mem_rleft;
                n_out_right = mem_rright;
                n_out_last  = (r_rem == CNT_W'(1));
                n_rem       = r_rem - CNT_W'(1);
                n_state     = (r_rem == CNT_W'(1)) ? ST_IDLE : ST_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wp        <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= TRIG_FREE;
            r_level     <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else if (i_cfg_idx == CFG_LEVEL) begin
                    r_level <= t_samp'(i_cfg_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_scnt      <= n_scnt;
        r_rem       <= n_rem;
        r_cur       <= n_cur;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_right, r_out_left};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for triggered_capture_ring_top: stream requests in, window pairs out.
// Holds its own model of the ring, pointer and trigger registers; depends on trc_pkg.
// Directed table first, then random phases with varied trigger settings and idling.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trc_pkg::*;

    localparam logic [1:0] TRIG_ODD    = 2'd3;
    localparam int         NPHASE      = 8;
    localparam int         PHASE_ITEMS = 46;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE_CYC  = 32;
    localparam int         CYCLE_LIMIT = 4_000_000;

    typedef struct {
        t_samp left;
        t_samp right;
        logic  last;
    } t_pair;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SHOW,
        ROW_SHOW_CHK,
        ROW_CFG
    } t_row_op;

    typedef struct {
        t_row_op     op;
        logic        cfg_idx;
        logic [15:0] d_left;
        logic [15:0] d_right;
        logic [6:0]  cnt;
        logic [15:0] want_l;
        logic [15:0] want_r;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_idx;
    logic [SAMP_W-1:0]         i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic                      m_axis_tlast;

    t_samp       ring_left  [RING_DEPTH];
    t_samp       ring_right [RING_DEPTH];
    t_ptr        wr_ptr;
    logic [1:0]  trig_mode;
    t_samp       trig_level;
    t_pair       pending_pairs[$];
    t_pair       want;
    t_dir_row    dir_tab[$];

    int          mismatches   = 0;
    int          cycle_cnt    = 0;
    int          n_writes     = 0;
    int          n_windows    = 0;
    int          n_settings   = 0;
    int          pairs_seen   = 0;
    int          holds_done   = 0;
    bit          gaps_en      = 1'b0;
    bit          stall_en     = 1'b0;
    bit          hold_off_req = 1'b0;

    triggered_capture_ring_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] left, [31:16] right, [38:32] count, [39] 0
        .s_axis_tuser  (s_axis_tuser),    // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] out_left, [31:16] out_right
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d pairs still pending",
                     cycle_cnt, pending_pairs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    endtask

    function automatic bit crossing_at(input t_ptr idx);
        t_samp cur;
        t_samp old;
        cur = ring_left[idx];
        old = ring_left[idx - t_ptr'(1)];
        if (trig_mode == TRIG_RISE)
            return (old < trig_level) && (cur >= trig_level);
        if (trig_mode == TRIG_FALL)
            return (old > trig_level) && (cur <= trig_level);
        return 1'b0;
    endfunction

    // Update the ring on a write; on a display, locate the window and queue its pairs.
    task automatic capture_predict(input logic kind, input t_samp l, input t_samp r,
                                   input logic [6:0] cnt_in, input bit typed,
                                   input t_samp tl, input t_samp tr);
        int    n;
        int    i;
        t_ptr  first;
        t_ptr  idx;
        t_pair pr;
        if (kind == KIND_WRITE) begin
            ring_left[wr_ptr]  = l;
            ring_right[wr_ptr] = r;
            wr_ptr++;
            n_writes++;
            return;
        end
        n_windows++;
        n = (cnt_in > MAX_WINDOW) ? MAX_WINDOW : int'(cnt_in);
        if (n == 0)
            return;
        first = wr_ptr - t_ptr'(n);
        if (trig_mode == TRIG_RISE || trig_mode == TRIG_FALL) begin
            for (i = 0; i < HALF_RING; i++) begin
                idx = wr_ptr - t_ptr'(n) - t_ptr'(i);
                if (crossing_at(idx)) begin
                    first = idx;
                    break;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            pr.left  = typed ? tl : ring_left[first + t_ptr'(i)];
            pr.right = typed ? tr : ring_right[first + t_ptr'(i)];
            pr.last  = (i == n - 1);
            pending_pairs.push_back(pr);
        end
    endtask

    // Offer one request from a falling edge and hold it until taken.
    task automatic send_req(input logic kind, input t_samp l, input t_samp r,
                            input logic [6:0] cnt, input bit typed,
                            input t_samp tl, input t_samp tr);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {1'b0, cnt, r, l};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        capture_predict(kind, l, r, cnt, typed, tl, tr);
        @(negedge i_clk);
        if (gaps_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    task automatic settle_idle();
        s_axis_tvalid = 1'b0;
        while (pending_pairs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        if (idx == CFG_MODE)
            trig_mode = val[1:0];
        else
            trig_level = t_samp'(val);
        n_settings++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_samp near_level(input int off);
        int v;
        v = int'(trig_level) + off;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return t_samp'(v);
    endfunction

    // Receiver: short random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
                holds_done++;
            end else if (stall_left != 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (stall_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 4);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pairs_seen++;
            if (pending_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %h last %b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_pairs.pop_front();
                if (m_axis_tdata[15:0] !== want.left)
                    report_mismatch($sformatf("out_left %h, want %h",
                                              m_axis_tdata[15:0], want.left));
                if (m_axis_tdata[31:16] !== want.right)
                    report_mismatch($sformatf("out_right %h, want %h",
                                              m_axis_tdata[31:16], want.right));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
            end
        end
    end

    initial begin
        logic [1:0]  phase_mode [NPHASE];
        logic [15:0] lvl;
        logic [6:0]  cnt;
        t_samp       l;
        t_samp       r;
        bit          wave_hi;
        int          run_left;
        bit          hold_armed;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MODE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_WRITE;
        foreach (ring_left[k]) begin
            ring_left[k]  = '0;
            ring_right[k] = '0;
        end
        wr_ptr     = '0;
        trig_mode  = TRIG_FREE;
        trig_level = '0;
        wave_hi    = 1'b0;
        run_left   = 0;
        hold_armed = 1'b0;
        phase_mode = '{TRIG_RISE, TRIG_FALL, TRIG_FREE, TRIG_RISE,
                       TRIG_ODD, TRIG_FALL, TRIG_RISE, TRIG_FALL};

        //            op            idx        left      right     cnt     want_l    want_r
        dir_tab = '{
            '{ROW_SHOW_CHK, CFG_MODE,  16'h0000, 16'h0000, 7'd1,   16'h0000, 16'h0000},
            '{ROW_SHOW_CHK, CFG_MODE,  16'h0000, 16'h0000, 7'd0,   16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'h7FFF, 16'h8000, 7'd127, 16'h0000, 16'h0000},
            '{ROW_SHOW_CHK, CFG_MODE,  16'hFFFF, 16'hFFFF, 7'd1,   16'h7FFF, 16'h8000},
            '{ROW_WRITE,    CFG_MODE,  16'h8000, 16'h7FFF, 7'd0,   16'h0000, 16'h0000},
            '{ROW_SHOW_CHK, CFG_MODE,  16'h0000, 16'h0000, 7'd1,   16'h8000, 16'h7FFF},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd127, 16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd64,  16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_MODE,  16'(TRIG_RISE), 16'h0000, 7'd0, 16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'hFF9C, 16'h1234, 7'd0,   16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'h0064, 16'h5678, 7'd0,   16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'h0005, 16'h0000, 7'd0,   16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'h0006, 16'hFFFF, 7'd0,   16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd2,   16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd1,   16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_MODE,  16'(TRIG_FALL), 16'h0000, 7'd0, 16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_LEVEL, 16'h8000, 16'h0000, 7'd0,   16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd4,   16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_LEVEL, 16'h7FFF, 16'h0000, 7'd0,   16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_MODE,  16'(TRIG_RISE), 16'h0000, 7'd0, 16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd3,   16'h0000, 16'h0000},
            '{ROW_CFG,      CFG_MODE,  16'(TRIG_ODD), 16'h0000, 7'd0, 16'h0000, 16'h0000},
            '{ROW_SHOW_CHK, CFG_MODE,  16'h0000, 16'h0000, 7'd1,   16'h0006, 16'hFFFF},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd65,  16'h0000, 16'h0000},
            '{ROW_WRITE,    CFG_MODE,  16'h5555, 16'hAAAA, 7'd85,  16'h0000, 16'h0000},
            '{ROW_SHOW,     CFG_MODE,  16'h0000, 16'h0000, 7'd0,   16'h0000, 16'h0000}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        gaps_en  = 1'b1;
        stall_en = 1'b1;

        foreach (dir_tab[k]) begin
            case (dir_tab[k].op)
                ROW_CFG: begin
                    settle_idle();
                    write_reg(dir_tab[k].cfg_idx, dir_tab[k].d_left);
                end
                ROW_WRITE: begin
                    send_req(KIND_WRITE, t_samp'(dir_tab[k].d_left), t_samp'(dir_tab[k].d_right),
                             dir_tab[k].cnt, 1'b0, '0, '0);
                end
                default: begin
                    send_req(KIND_DISPLAY, t_samp'(dir_tab[k].d_left),
                             t_samp'(dir_tab[k].d_right), dir_tab[k].cnt,
                             dir_tab[k].op == ROW_SHOW_CHK,
                             t_samp'(dir_tab[k].want_l), t_samp'(dir_tab[k].want_r));
                end
            endcase
        end

        for (int p = 0; p < NPHASE; p++) begin
            settle_idle();
            gaps_en    = (p % 3 != 1) && (p != NPHASE - 1);
            stall_en   = gaps_en;
            hold_armed = (p == 2);
            case ($urandom_range(0, 5))
                0:       lvl = 16'h8000;
                1:       lvl = 16'h7FFF;
                2:       lvl = 16'h0000;
                default: lvl = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_MODE, 16'(phase_mode[p]));
            write_reg(CFG_LEVEL, lvl);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 9))
                        0:       cnt = 7'd0;
                        1:       cnt = 7'($urandom_range(65, 127));
                        2:       cnt = 7'd64;
                        default: cnt = 7'($urandom_range(1, 63));
                    endcase
                    if (hold_armed) begin
                        cnt          = 7'd64;
                        hold_off_req = 1'b1;
                        hold_armed   = 1'b0;
                    end
                    send_req(KIND_DISPLAY, t_samp'($urandom_range(0, 65535)),
                             t_samp'($urandom_range(0, 65535)), cnt, 1'b0, '0, '0);
                end else begin
                    if (run_left == 0) begin
                        wave_hi  = !wave_hi;
                        run_left = $urandom_range(1, 40);
                    end
                    run_left--;
                    case ($urandom_range(0, 9))
                        0, 1:    l = t_samp'($urandom_range(0, 65535));
                        2:       l = trig_level;
                        default: l = near_level(wave_hi ? int'($urandom_range(0, 3000))
                                                        : -int'($urandom_range(1, 3000)));
                    endcase
                    r = ($urandom_range(0, 3) == 0) ? l : t_samp'($urandom_range(0, 65535));
                    send_req(KIND_WRITE, l, r, 7'($urandom_range(0, 127)), 1'b0, '0, '0);
                end
            end
        end

        settle_idle();
        $display("Summary: %0d requests (%0d sample writes, %0d windows), %0d pairs checked",
                 n_writes + n_windows, n_writes, n_windows, pairs_seen);
        $display("Summary: %0d register writes, %0d long receiver hold-off(s), %0d mismatches",
                 n_settings, holds_done, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
